FILE: hdl/bfs3_pkg.sv
// Shared types and constants for the distance-three breadth-first search block.
`default_nettype none
package bfs3_pkg;

	localparam int MAX_NODES_DEF = 64;
	localparam int NODE_SLOTS    = 64;
	localparam int NODE_W        = 6;
	localparam int CNT_W         = 7;
	localparam int DIST_W        = 2;

	localparam logic [DIST_W-1:0] TARGET_DIST = 2'd3;

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	localparam logic [1:0] ST_ADDED = 2'd0;
	localparam logic [1:0] ST_BAD   = 2'd1;
	localparam logic [1:0] ST_PAIR  = 2'd2;
	localparam logic [1:0] ST_NONE  = 2'd3;

	typedef struct packed {
		logic              opcode;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
	} bfs3_req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [NODE_W-1:0] source_node;
		logic [NODE_W-1:0] target_node;
		logic              last;
	} bfs3_rsp_t;

endpackage
`default_nettype wire

FILE: hdl/bfs3_adj_mem.sv
// Adjacency row memory with per-row valid bits cleared at reset.
`default_nettype none
module bfs3_adj_mem #(
	parameter int ROWS = bfs3_pkg::NODE_SLOTS,
	parameter int RW   = $clog2(ROWS)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            rd_en,
	input  wire logic [RW-1:0]   rd_addr,
	output logic      [ROWS-1:0] rd_data,
	input  wire logic            wr_en,
	input  wire logic [RW-1:0]   wr_addr,
	input  wire logic [ROWS-1:0] wr_data
);

	logic [ROWS-1:0] mem [ROWS];
	logic [ROWS-1:0] row_vld_q;
	logic [ROWS-1:0] rd_q;
	logic            rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_vld_q <= row_vld_q[rd_addr];
			end
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule
`default_nettype wire

FILE: hdl/bfs3_ctrl.sv
// Request sequencer: edge insertion, queue-based search and result walk.
`default_nettype none
module bfs3_ctrl #(
	parameter int ROWS = bfs3_pkg::NODE_SLOTS,
	parameter int RW   = $clog2(ROWS)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [bfs3_pkg::CNT_W-1:0] cfg_wr_data,
	input  wire logic                       req_valid,
	output logic                            req_stall,
	input  wire bfs3_pkg::bfs3_req_t        req_data,
	output logic                            rsp_valid,
	input  wire logic                       rsp_ready,
	output bfs3_pkg::bfs3_rsp_t             rsp_data,
	output logic                            adj_re,
	output logic      [RW-1:0]              adj_raddr,
	input  wire logic [ROWS-1:0]            adj_rdata,
	output logic                            adj_we,
	output logic      [RW-1:0]              adj_waddr,
	output logic      [ROWS-1:0]            adj_wdata
);

	localparam int CW = RW + 1;
	localparam int QW = bfs3_pkg::DIST_W + RW;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DECODE  = 4'd1;
	localparam logic [3:0] S_EDGE_A  = 4'd2;
	localparam logic [3:0] S_EDGE_B  = 4'd3;
	localparam logic [3:0] S_RESP    = 4'd4;
	localparam logic [3:0] S_DQ_RD   = 4'd5;
	localparam logic [3:0] S_DQ_ROW  = 4'd6;
	localparam logic [3:0] S_DQ_LOAD = 4'd7;
	localparam logic [3:0] S_SCAN    = 4'd8;
	localparam logic [3:0] S_EM_RD   = 4'd9;
	localparam logic [3:0] S_EM_CHK  = 4'd10;

	logic [3:0]                       state_q;
	bfs3_pkg::bfs3_req_t              req_q;
	bfs3_pkg::bfs3_rsp_t              rsp_q;
	logic [bfs3_pkg::CNT_W-1:0]       ncount_q;
	logic [ROWS-1:0]                  visited_q;
	logic [ROWS-1:0]                  pend_q;
	logic [CW-1:0]                    head_q;
	logic [CW-1:0]                    tail_q;
	logic [CW-1:0]                    idx_q;
	logic [CW-1:0]                    pairs_q;
	logic [CW-1:0]                    sent_q;
	logic [bfs3_pkg::DIST_W-1:0]      cur_dist_q;

	logic [QW-1:0]                    q_mem [ROWS];
	logic [QW-1:0]                    q_rd_q;
	logic                             q_re;
	logic [RW-1:0]                    q_raddr;
	logic                             q_we;
	logic [RW-1:0]                    q_waddr;
	logic [QW-1:0]                    q_wdata;

	logic [bfs3_pkg::CNT_W-1:0]       n_use;
	logic                             a_bad;
	logic                             b_bad;
	logic                             bad;
	logic [RW-1:0]                    a_idx;
	logic [RW-1:0]                    b_idx;
	logic [ROWS-1:0]                  use_mask;
	logic [ROWS-1:0]                  low;
	logic [RW-1:0]                    nb_idx;
	logic [RW-1:0]                    q_node;
	logic [bfs3_pkg::DIST_W-1:0]      q_dist;
	logic [bfs3_pkg::DIST_W-1:0]      nb_dist;
	logic                             em_last;

	assign n_use   = (ncount_q > bfs3_pkg::CNT_W'(ROWS)) ? bfs3_pkg::CNT_W'(ROWS) : ncount_q;
	assign a_bad   = {1'b0, req_q.node_a} >= n_use;
	assign b_bad   = {1'b0, req_q.node_b} >= n_use;
	assign bad     = a_bad || (req_q.opcode == bfs3_pkg::OP_ADD && b_bad);
	assign a_idx   = req_q.node_a[RW-1:0];
	assign b_idx   = req_q.node_b[RW-1:0];
	assign q_node  = q_rd_q[RW-1:0];
	assign q_dist  = q_rd_q[QW-1:RW];
	assign nb_dist = cur_dist_q + bfs3_pkg::DIST_W'(1);
	assign low     = pend_q & (~pend_q + ROWS'(1));
	assign em_last = (sent_q + CW'(1)) == pairs_q;

	always_comb begin
		for (int k = 0; k < ROWS; k++) begin
			use_mask[k] = bfs3_pkg::CNT_W'(k) < n_use;
		end
	end

	always_comb begin
		nb_idx = '0;
		for (int k = 0; k < ROWS; k++) begin
			if (low[k]) begin
				nb_idx = nb_idx | RW'(k);
			end
		end
	end

	// memory port control
	always_comb begin
		adj_re    = 1'b0;
		adj_raddr = a_idx;
		adj_we    = 1'b0;
		adj_waddr = a_idx;
		adj_wdata = adj_rdata | (ROWS'(1) << b_idx);
		q_re      = 1'b0;
		q_raddr   = head_q[RW-1:0];
		q_we      = 1'b0;
		q_waddr   = tail_q[RW-1:0];
		q_wdata   = {nb_dist, nb_idx};
		unique case (state_q)
			S_DECODE: begin
				adj_re  = !bad && req_q.opcode == bfs3_pkg::OP_ADD;
				q_we    = !bad && req_q.opcode == bfs3_pkg::OP_SEARCH;
				q_waddr = '0;
				q_wdata = {bfs3_pkg::DIST_W'(0), a_idx};
			end
			S_EDGE_A: begin
				adj_re    = 1'b1;
				adj_raddr = b_idx;
				adj_we    = 1'b1;
			end
			S_EDGE_B: begin
				adj_we    = 1'b1;
				adj_waddr = b_idx;
				adj_wdata = adj_rdata | (ROWS'(1) << a_idx);
			end
			S_DQ_RD: begin
				q_re = head_q < tail_q;
			end
			S_DQ_ROW: begin
				adj_re    = q_dist != bfs3_pkg::TARGET_DIST;
				adj_raddr = q_node;
			end
			S_SCAN: begin
				q_we = pend_q != '0;
			end
			S_EM_RD: begin
				q_re    = 1'b1;
				q_raddr = idx_q[RW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[q_waddr] <= q_wdata;
		end
		if (q_re) begin
			q_rd_q <= q_mem[q_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ncount_q   <= '0;
			visited_q  <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			idx_q      <= '0;
			pairs_q    <= '0;
			sent_q     <= '0;
			pend_q     <= '0;
			cur_dist_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				ncount_q <= cfg_wr_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (bad) begin
						state_q <= S_RESP;
					end else if (req_q.opcode == bfs3_pkg::OP_ADD) begin
						state_q <= S_EDGE_A;
					end else begin
						visited_q <= ROWS'(1) << a_idx;
						head_q    <= '0;
						tail_q    <= CW'(1);
						pairs_q   <= '0;
						state_q   <= S_DQ_RD;
					end
				end
				S_EDGE_A: begin
					state_q <= S_EDGE_B;
				end
				S_EDGE_B: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				S_DQ_RD: begin
					if (head_q < tail_q) begin
						head_q  <= head_q + CW'(1);
						state_q <= S_DQ_ROW;
					end else if (pairs_q == '0) begin
						state_q <= S_RESP;
					end else begin
						idx_q   <= '0;
						sent_q  <= '0;
						state_q <= S_EM_RD;
					end
				end
				S_DQ_ROW: begin
					cur_dist_q <= q_dist;
					if (q_dist == bfs3_pkg::TARGET_DIST) begin
						state_q <= S_DQ_RD;
					end else begin
						state_q <= S_DQ_LOAD;
					end
				end
				S_DQ_LOAD: begin
					pend_q  <= adj_rdata & ~visited_q & use_mask;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (pend_q == '0) begin
						state_q <= S_DQ_RD;
					end else begin
						visited_q <= visited_q | low;
						pend_q    <= pend_q & ~low;
						tail_q    <= tail_q + CW'(1);
						if (nb_dist == bfs3_pkg::TARGET_DIST) begin
							pairs_q <= pairs_q + CW'(1);
						end
					end
				end
				S_EM_RD: begin
					idx_q   <= idx_q + CW'(1);
					state_q <= S_EM_CHK;
				end
				S_EM_CHK: begin
					if (q_dist != bfs3_pkg::TARGET_DIST) begin
						state_q <= S_EM_RD;
					end else if (rsp_ready) begin
						sent_q  <= sent_q + CW'(1);
						state_q <= em_last ? S_IDLE : S_EM_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// hold request and single-result payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			req_q <= req_data;
		end
		if (state_q == S_DECODE) begin
			rsp_q.status      <= bad ? bfs3_pkg::ST_BAD : bfs3_pkg::ST_ADDED;
			rsp_q.source_node <= req_q.node_a;
			rsp_q.target_node <= (req_q.opcode == bfs3_pkg::OP_ADD) ? req_q.node_b : '0;
			rsp_q.last        <= 1'b1;
		end else if (state_q == S_DQ_RD && head_q >= tail_q) begin
			rsp_q.status      <= bfs3_pkg::ST_NONE;
			rsp_q.target_node <= '0;
		end
	end

	assign req_stall = state_q != S_IDLE;

	always_comb begin
		rsp_valid = 1'b0;
		rsp_data  = rsp_q;
		if (state_q == S_RESP) begin
			rsp_valid = 1'b1;
		end else if (state_q == S_EM_CHK && q_dist == bfs3_pkg::TARGET_DIST) begin
			rsp_valid            = 1'b1;
			rsp_data.status      = bfs3_pkg::ST_PAIR;
			rsp_data.source_node = req_q.node_a;
			rsp_data.target_node = bfs3_pkg::NODE_W'(q_node);
			rsp_data.last        = em_last;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/bfs_distance_three_pairs_top.sv
// An edge request passes decode, two adjacency update states and the response state;
// a rejected one goes from decode straight to the response state. A search dequeues each
// node, reads its adjacency row unless the node is at distance three, enqueues unvisited
// neighbours one per cycle, then walks the queue to emit each distance-three pair.
// One request at a time; output stalls hold the sequencer; results leave through a register.
// Reset clears the adjacency matrix valid bits, node count and control state.
`default_nettype none
module bfs_distance_three_pairs_top #(
	parameter int MAX_NODES = bfs3_pkg::MAX_NODES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [bfs3_pkg::CNT_W-1:0] cfg_wr_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire bfs3_pkg::bfs3_req_t        in_data,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output bfs3_pkg::bfs3_rsp_t             out_data
);

	localparam int ROWS = (MAX_NODES < bfs3_pkg::NODE_SLOTS) ? MAX_NODES : bfs3_pkg::NODE_SLOTS;
	localparam int RW   = $clog2(ROWS);

	logic                rsp_valid;
	logic                rsp_ready;
	bfs3_pkg::bfs3_rsp_t rsp_data;
	logic                adj_re;
	logic [RW-1:0]       adj_raddr;
	logic [ROWS-1:0]     adj_rdata;
	logic                adj_we;
	logic [RW-1:0]       adj_waddr;
	logic [ROWS-1:0]     adj_wdata;
	logic                out_valid_q;
	bfs3_pkg::bfs3_rsp_t out_q;

	bfs3_ctrl #(
		.ROWS (ROWS),
		.RW   (RW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_valid   (in_valid),
		.req_stall   (in_stall),
		.req_data    (in_data),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp_data    (rsp_data),
		.adj_re      (adj_re),
		.adj_raddr   (adj_raddr),
		.adj_rdata   (adj_rdata),
		.adj_we      (adj_we),
		.adj_waddr   (adj_waddr),
		.adj_wdata   (adj_wdata)
	);

	bfs3_adj_mem #(
		.ROWS (ROWS),
		.RW   (RW)
	) u_adj_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (adj_re),
		.rd_addr (adj_raddr),
		.rd_data (adj_rdata),
		.wr_en   (adj_we),
		.wr_addr (adj_waddr),
		.wr_data (adj_wdata)
	);

	assign rsp_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_ready) begin
			out_valid_q <= rsp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_ready && rsp_valid) begin
			out_q <= rsp_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire
